>>> src/ubx_pkg.sv
// ----------------------------------------------------------------------------
// UBX frame receiver package
// Shared types, message codes and defaults for the UBX byte-stream parser.
// ----------------------------------------------------------------------------
package ubx_pkg;

  localparam int unsigned DefaultMaxPayload = 128;

  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;

  localparam logic [7:0] ClassNav = 8'h01;
  localparam logic [7:0] ClassAck = 8'h05;
  localparam logic [7:0] ClassCfg = 8'h06;

  localparam logic [7:0] IdAckNak     = 8'h00;
  localparam logic [7:0] IdAckAck     = 8'h01;
  localparam logic [7:0] IdNavPosecef = 8'h01;
  localparam logic [7:0] IdNavPvt     = 8'h07;
  localparam logic [7:0] IdCfgNav5    = 8'h24;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_B
  } ubx_phase_e;

  typedef enum logic [3:0] {
    RC_WAIT         = 4'd0,
    RC_ACK          = 4'd1,
    RC_NAK          = 4'd2,
    RC_NAV_PVT      = 4'd3,
    RC_NAV_POSECEF  = 4'd4,
    RC_CFG_NAV5     = 4'd5,
    RC_UNHANDLED    = 4'd6,
    RC_BAD_CHECKSUM = 4'd7,
    RC_TOO_LONG     = 4'd8
  } ubx_code_e;

  typedef struct packed {
    ubx_code_e  code;
    logic [7:0] msg_cls;
    logic [7:0] msg_id;
    logic [6:0] payload_length;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
  } ubx_result_t;

endpackage

>>> src/ubx_frame_receiver.sv
// ----------------------------------------------------------------------------
// UBX frame receiver
// Byte-serial UBX parser with Fletcher-8 check and message classification.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-----------------------------
//   rx byte  | in        | in_valid_i / in_ready_o   | rx_byte_i
//   result   | out       | out_valid_o / out_ready_i | result_code_o, msg_cls_o,
//            |           |                           | msg_id_o, payload_length_o,
//            |           |                           | payload_valid_o, payload_byte_o,
//            |           |                           | payload_index_o
//
// One byte per cycle sustained while the result sink keeps up; each byte gives exactly one result request.
// Each byte passes through the input register, then the parse logic into the
// result register. The phase machine and running sums update once per byte.
// rst_ni clears the frame state to hunting for the first sync byte.
// A stalled result holds in its register; the input register keeps taking
// bytes until both registers are full.
// ----------------------------------------------------------------------------
module ubx_frame_receiver #(
  parameter int unsigned MaxPayload = ubx_pkg::DefaultMaxPayload
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] result_code_o,
  output logic [7:0] msg_cls_o,
  output logic [7:0] msg_id_o,
  output logic [6:0] payload_length_o,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic [6:0] payload_index_o
);
  import ubx_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  ubx_result_t res_q;
  ubx_result_t res_d;
  logic        advance;
  logic        step;
  logic        in_take;

  // Advance the parse stage when the result register is free or draining.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = advance && in_valid_q;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  // Input register: hold the byte until the parse stage consumes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  ubx_parser #(
    .MaxPayload (MaxPayload)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (res_d)
  );

  // Result register: hold the request until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_code_o    = res_q.code;
  assign msg_cls_o        = res_q.msg_cls;
  assign msg_id_o         = res_q.msg_id;
  assign payload_length_o = res_q.payload_length;
  assign payload_valid_o  = res_q.payload_valid;
  assign payload_byte_o   = res_q.payload_byte;
  assign payload_index_o  = res_q.payload_index;

`ifndef SYNTHESIS
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("buffered byte lost while the result stage stalled");

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("parsed byte did not reach the result register");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && !$past(step)))
    else $error("result register overwritten while stalled");
`endif

endmodule

>>> src/ubx_classify.sv
// ----------------------------------------------------------------------------
// UBX message classifier
// Map a class/id pair onto the result code of a frame with a good checksum.
// ----------------------------------------------------------------------------
module ubx_classify (
  input  logic [7:0]         msg_cls_i,
  input  logic [7:0]         msg_id_i,
  output ubx_pkg::ubx_code_e code_o
);
  import ubx_pkg::*;

  always_comb begin
    code_o = RC_UNHANDLED;
    unique case (msg_cls_i)
      ClassAck: begin
        if (msg_id_i == IdAckNak) code_o = RC_NAK;
        else if (msg_id_i == IdAckAck) code_o = RC_ACK;
      end
      ClassNav: begin
        if (msg_id_i == IdNavPvt) code_o = RC_NAV_PVT;
        else if (msg_id_i == IdNavPosecef) code_o = RC_NAV_POSECEF;
      end
      ClassCfg: begin
        if (msg_id_i == IdCfgNav5) code_o = RC_CFG_NAV5;
      end
      default: code_o = RC_UNHANDLED;
    endcase
  end

endmodule

>>> src/ubx_parser.sv
// ----------------------------------------------------------------------------
// UBX frame parser core
// Frame phase machine with running Fletcher-8 sums; one byte per step.
// ----------------------------------------------------------------------------
module ubx_parser #(
  parameter int unsigned MaxPayload = ubx_pkg::DefaultMaxPayload
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output ubx_pkg::ubx_result_t result_o
);
  import ubx_pkg::*;

  localparam int unsigned IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned LenW = (IdxW > 8) ? IdxW : 8;

  ubx_phase_e      phase_q, phase_d;
  logic [7:0]      class_q, class_d;
  logic [7:0]      id_q, id_d;
  logic [LenW-1:0] len_q, len_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_a_q, sum_a_d;
  logic [7:0]      sum_b_q, sum_b_d;
  logic [7:0]      ck_a_q, ck_a_d;

  logic [15:0]     full_len;
  logic            too_long;
  logic [LenW-1:0] idx_ext;
  logic            in_payload;
  logic [7:0]      add_a;
  logic [7:0]      add_b;
  logic            ck_ok;
  ubx_code_e       class_code;

  assign full_len   = {byte_i, len_q[7:0]};
  assign too_long   = full_len >= 16'(MaxPayload);
  assign idx_ext    = LenW'(idx_q);
  assign in_payload = idx_ext != len_q;
  assign add_a      = sum_a_q + byte_i;
  assign add_b      = sum_b_q + add_a;
  assign ck_ok      = (ck_a_q == sum_a_q) && (byte_i == sum_b_q);

  ubx_classify u_classify (
    .msg_cls_i (class_q),
    .msg_id_i  (id_q),
    .code_o    (class_code)
  );

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE:    if (byte_i == SyncFirst) phase_d = PH_SYNC;
      PH_SYNC:    phase_d = (byte_i == SyncSecond) ? PH_CLASS : PH_IDLE;
      PH_CLASS:   phase_d = PH_ID;
      PH_ID:      phase_d = PH_LEN_LO;
      PH_LEN_LO:  phase_d = PH_LEN_HI;
      PH_LEN_HI:  phase_d = too_long ? PH_IDLE : PH_PAYLOAD;
      PH_PAYLOAD: if (!in_payload) phase_d = PH_CK_B;
      PH_CK_B:    phase_d = PH_IDLE;
      default:    phase_d = PH_IDLE;
    endcase
  end

  // Frame fields, sums and result
  always_comb begin
    class_d  = class_q;
    id_d     = id_q;
    len_d    = len_q;
    idx_d    = idx_q;
    sum_a_d  = sum_a_q;
    sum_b_d  = sum_b_q;
    ck_a_d   = ck_a_q;
    result_o = '0;
    result_o.code = RC_WAIT;
    unique case (phase_q)
      PH_CLASS: begin
        class_d = byte_i;
        sum_a_d = byte_i;
        sum_b_d = byte_i;
      end
      PH_ID: begin
        id_d    = byte_i;
        sum_a_d = add_a;
        sum_b_d = add_b;
      end
      PH_LEN_LO: begin
        len_d   = LenW'(byte_i);
        sum_a_d = add_a;
        sum_b_d = add_b;
      end
      PH_LEN_HI: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        idx_d   = '0;
        if (too_long) result_o.code = RC_TOO_LONG;
        else len_d = LenW'(full_len);
      end
      PH_PAYLOAD: begin
        if (in_payload) begin
          idx_d                  = idx_q + IdxW'(1);
          sum_a_d                = add_a;
          sum_b_d                = add_b;
          result_o.payload_valid = 1'b1;
          result_o.payload_byte  = byte_i;
          result_o.payload_index = idx_ext[6:0];
        end else begin
          ck_a_d = byte_i;
        end
      end
      PH_CK_B: begin
        result_o.code = ck_ok ? class_code : RC_BAD_CHECKSUM;
      end
      default: ;
    endcase
    result_o.msg_cls        = class_d;
    result_o.msg_id         = id_d;
    result_o.payload_length = len_d[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      class_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      ck_a_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      ck_a_q  <= ck_a_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (idx_ext <= len_q))
    else $error("payload index ran past the declared length");

  a_too_long_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.code == RC_TOO_LONG) |=> (phase_q == PH_IDLE))
    else $error("too-long frame did not return to hunt");

  a_final_code_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.code != RC_WAIT) |-> (phase_q == PH_CK_B || phase_q == PH_LEN_HI))
    else $error("frame result outside the end of a frame");
`endif

endmodule
